FILE: src/tpa_pkg.sv
// ----------------------------------------------------------------------------
// tpa_pkg: shared types and constants of the touch point to angle unit
// Register codes, quadrant codes, the item control struct and the CORDIC
// arctangent table in degrees with 16 fraction bits.
// ----------------------------------------------------------------------------
package tpa_pkg;

  // Fraction bits of the CORDIC angle accumulator (degrees).
  localparam int ZFRAC = 16;
  // Width of the signed angle accumulator: the table sums below 2^23.
  localparam int ZW = 25;
  // Stages that have a table entry.
  localparam int TAB_LEN = 24;
  // Width of one table entry.
  localparam int TAB_W = 22;

  // Register reset values.
  localparam int BOX_LEFT_RST = 150;
  localparam int BOX_TOP_RST  = 0;
  localparam int BOX_SIZE_RST = 200;

  typedef enum logic [1:0] {
    REG_BOX_LEFT = 2'd0,
    REG_BOX_TOP  = 2'd1,
    REG_BOX_SIZE = 2'd2
  } reg_idx_t;

  // Quadrant of the touch about the center; the base angle is code * 90.
  typedef enum logic [1:0] {
    QUAD_UP    = 2'd0,
    QUAD_LEFT  = 2'd1,
    QUAD_DOWN  = 2'd2,
    QUAD_RIGHT = 2'd3
  } quad_t;

  typedef struct packed {
    logic  in_box;
    logic  centre;
    quad_t quad;
  } item_ctl_t;

  // atan(2^-i) in degrees times 65536, rounded to nearest.
  function automatic logic [TAB_W-1:0] atan_tab(input int i);
    logic [TAB_W-1:0] v;
    v = '0;
    unique case (i)
      0:  v = 22'd2949120;
      1:  v = 22'd1740967;
      2:  v = 22'd919879;
      3:  v = 22'd466945;
      4:  v = 22'd234379;
      5:  v = 22'd117304;
      6:  v = 22'd58666;
      7:  v = 22'd29335;
      8:  v = 22'd14668;
      9:  v = 22'd7334;
      10: v = 22'd3667;
      11: v = 22'd1833;
      12: v = 22'd917;
      13: v = 22'd458;
      14: v = 22'd229;
      15: v = 22'd115;
      16: v = 22'd57;
      17: v = 22'd29;
      18: v = 22'd14;
      19: v = 22'd7;
      20: v = 22'd4;
      21: v = 22'd2;
      22: v = 22'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/tpa_fifo.sv
// ----------------------------------------------------------------------------
// tpa_fifo: small synchronous queue
// Register-file queue with push/full and pop/empty; the head is shown on rdata.
// ----------------------------------------------------------------------------
module tpa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/tpa_front.sv
// ----------------------------------------------------------------------------
// tpa_front: box registers and touch classification
// Holds the box registers, tests the touch against the box and finds the
// quadrant and the CORDIC numerator and denominator.
// ----------------------------------------------------------------------------
module tpa_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [COORD_BITS-1:0]   cfg_data,
  input  logic [COORD_BITS-1:0]   touch_x,
  input  logic [COORD_BITS-1:0]   touch_y,
  output tpa_pkg::item_ctl_t      ctl,
  output logic [COORD_BITS-1:0]   num,
  output logic [COORD_BITS-1:0]   den
);
  import tpa_pkg::*;

  localparam int W = COORD_BITS;

  logic [W-1:0]        box_left;
  logic [W-1:0]        box_top;
  logic [W-1:0]        box_size;
  logic [W:0]          right_edge;
  logic [W:0]          bottom_edge;
  logic [W:0]          cen_x;
  logic [W:0]          cen_y;
  logic signed [W+1:0] dx;
  logic signed [W+1:0] dy;
  logic signed [W+1:0] adx;
  logic signed [W+1:0] ady;
  logic [W-1:0]        ax;
  logic [W-1:0]        ay;
  logic                dx_neg;
  logic                dy_neg;
  logic                dx_zero;
  logic                dy_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_left <= W'(BOX_LEFT_RST);
      box_top  <= W'(BOX_TOP_RST);
      box_size <= W'(BOX_SIZE_RST);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BOX_LEFT: box_left <= cfg_data;
        REG_BOX_TOP:  box_top  <= cfg_data;
        REG_BOX_SIZE: box_size <= cfg_data;
        default: ;
      endcase
    end
  end

  // Compare edges one bit wider so a box past the screen does not wrap.
  assign right_edge  = {1'b0, box_left} + {1'b0, box_size};
  assign bottom_edge = {1'b0, box_top} + {1'b0, box_size};
  assign cen_x       = {1'b0, box_left} + {2'b0, box_size[W-1:1]};
  assign cen_y       = {1'b0, box_top} + {2'b0, box_size[W-1:1]};

  assign dx = $signed({2'b0, touch_x}) - $signed({1'b0, cen_x});
  assign dy = $signed({2'b0, touch_y}) - $signed({1'b0, cen_y});

  assign dx_neg  = dx[W+1];
  assign dy_neg  = dy[W+1];
  assign dx_zero = (dx == '0);
  assign dy_zero = (dy == '0);
  assign adx     = dx_neg ? -dx : dx;
  assign ady     = dy_neg ? -dy : dy;
  // Inside the box both offsets fit in W bits.
  assign ax      = adx[W-1:0];
  assign ay      = ady[W-1:0];

  always_comb begin
    ctl.in_box = (touch_x >= box_left) && ({1'b0, touch_x} <= right_edge) &&
                 (touch_y >= box_top) && ({1'b0, touch_y} <= bottom_edge);
    ctl.centre = dx_zero && dy_zero;
    priority if ((dx_neg || dx_zero) && dy_neg) begin
      ctl.quad = QUAD_UP;
      num      = ax;
      den      = ay;
    end else if (dx_neg) begin
      ctl.quad = QUAD_LEFT;
      num      = ay;
      den      = ax;
    end else if (!dy_neg && !dy_zero) begin
      ctl.quad = QUAD_DOWN;
      num      = ax;
      den      = ay;
    end else begin
      ctl.quad = QUAD_RIGHT;
      num      = ay;
      den      = ax;
    end
  end

endmodule

FILE: src/tpa_cordic.sv
// ----------------------------------------------------------------------------
// tpa_cordic: vectoring CORDIC pipeline and angle assembly
// One stage per CORDIC iteration, a rounding and clamping stage, then the
// quadrant base is added as the result leaves. The whole pipe stalls together.
// ----------------------------------------------------------------------------
module tpa_cordic #(
  parameter int COORD_BITS      = 12,
  parameter int ANGLE_FRAC_BITS = 6,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tpa_pkg::item_ctl_t            in_ctl,
  input  logic [COORD_BITS-1:0]         in_num,
  input  logic [COORD_BITS-1:0]         in_den,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_inside,
  output logic [ANGLE_FRAC_BITS+8:0]    out_angle
);
  import tpa_pkg::*;

  localparam int W   = COORD_BITS;
  localparam int S   = CORDIC_STAGES;
  localparam int NS  = (S < TAB_LEN) ? S : TAB_LEN;
  localparam int XW  = W + S + 3;
  localparam int F   = ANGLE_FRAC_BITS;
  localparam int AW  = F + 9;
  localparam int SH  = ZFRAC - F;
  localparam logic signed [ZW-1:0] RND   = ZW'(1) << (SH - 1);
  localparam logic signed [ZW-1:0] LIM_Z = ZW'(90 << F);
  localparam logic [AW-1:0]        LIM   = AW'(90 << F);
  localparam logic [AW-1:0]        FULL  = AW'(360 << F);

  logic signed [XW-1:0] x_q [NS+1];
  logic signed [XW-1:0] y_q [NS+1];
  logic signed [ZW-1:0] z_q [NS+1];
  item_ctl_t            c_q [NS+1];
  logic [NS:0]          v_q;

  logic                 fin_valid;
  item_ctl_t            fin_ctl;
  logic [AW-1:0]        fin_zr;

  logic                 advance;
  logic signed [ZW-1:0] z_rnd;
  logic [AW-1:0]        zr_next;
  logic [AW-1:0]        base;
  logic [AW-1:0]        total;

  // Advance everything unless the finished item is blocked.
  assign advance  = !fin_valid || out_ready;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q       <= '0;
      fin_valid <= 1'b0;
    end else if (advance) begin
      v_q       <= {v_q[NS-1:0], in_valid};
      fin_valid <= v_q[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x_q[0] <= $signed({3'b0, in_den, {S{1'b0}}});
      y_q[0] <= $signed({3'b0, in_num, {S{1'b0}}});
      z_q[0] <= '0;
      c_q[0] <= in_ctl;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] step;
    logic                 y_pos;

    assign xs    = x_q[i] >>> i;
    assign ys    = y_q[i] >>> i;
    assign step  = $signed(ZW'(atan_tab(i)));
    assign y_pos = !y_q[i][XW-1] && (y_q[i] != '0);

    always_ff @(posedge clk) begin
      if (advance) begin
        x_q[i+1] <= y_pos ? x_q[i] + ys : x_q[i] - ys;
        y_q[i+1] <= y_pos ? y_q[i] - xs : y_q[i] + xs;
        z_q[i+1] <= y_pos ? z_q[i] + step : z_q[i] - step;
        c_q[i+1] <= c_q[i];
      end
    end
  end

  // Round half up to the output precision, then clamp to [0, 90].
  assign z_rnd = (z_q[NS] + RND) >>> SH;

  always_comb begin
    priority if (z_rnd[ZW-1]) begin
      zr_next = '0;
    end else if (z_rnd > LIM_Z) begin
      zr_next = LIM;
    end else begin
      zr_next = AW'(z_rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fin_zr  <= zr_next;
      fin_ctl <= c_q[NS];
    end
  end

  always_comb begin
    unique case (fin_ctl.quad)
      QUAD_UP:    base = '0;
      QUAD_LEFT:  base = AW'(90 << F);
      QUAD_DOWN:  base = AW'(180 << F);
      QUAD_RIGHT: base = AW'(270 << F);
      default:    base = '0;
    endcase
  end

  assign total      = base + fin_zr;
  assign out_valid  = fin_valid;
  assign out_inside = fin_ctl.in_box;
  // Wrap a full turn to zero; outside points and the center give zero.
  assign out_angle  = (!fin_ctl.in_box || fin_ctl.centre || (total >= FULL)) ? '0 : total;

endmodule

FILE: src/touch_point_to_angle_unit.sv
// ----------------------------------------------------------------------------
// touch_point_to_angle_unit: joystick direction from a touch point
// Tests a touch against the joystick box and gives its angle about the box
// center in degrees with ANGLE_FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive touch_x/touch_y and raise push; the touch
//   transfers at a clock edge where push is high and full is low.
//   Result side is a queue: while empty is low, inside_box/angle_deg hold the
//   oldest result; it transfers at an edge where pop is high.
//   Every touch gives exactly one result, in order. Outside the box the
//   result is inside_box = 0, angle 0; the exact center gives angle 0.
//   Box registers are written through cfg_we/cfg_index/cfg_data (0: left,
//   1: top, 2: size), while no touch is in flight.
// Timing:
//   One touch per cycle sustained while the result queue is not full; the
//   pipe takes one item a cycle unless stalled. The CORDIC stage count sets
//   the latency: from the push edge to empty going low a touch passes the
//   CORDIC load from the input queue, the iteration stages (CORDIC_STAGES,
//   capped at 24), the rounding stage and the result queue write.
// Reset (rst, synchronous): queues empty, pipe drained, box registers back
//   to left 150, top 0, size 200.
// Stall: when pop stays low the result queue fills, the pipe holds in place,
//   then the input queue fills and full rises. Nothing is dropped.
// ----------------------------------------------------------------------------
module touch_point_to_angle_unit #(
  parameter int COORD_BITS      = 12,
  parameter int ANGLE_FRAC_BITS = 6,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  // touch input queue
  input  logic                         push,
  output logic                         full,
  input  logic [COORD_BITS-1:0]        touch_x,
  input  logic [COORD_BITS-1:0]        touch_y,
  // result queue
  output logic                         empty,
  input  logic                         pop,
  output logic                         inside_box,
  output logic [ANGLE_FRAC_BITS+8:0]   angle_deg
);
  import tpa_pkg::*;

  localparam int W      = COORD_BITS;
  localparam int AW     = ANGLE_FRAC_BITS + 9;
  localparam int CTL_W  = $bits(item_ctl_t);
  localparam int Q_W    = CTL_W + 2 * W;
  localparam int R_W    = AW + 1;
  localparam int Q_DEPTH = 4;
  localparam int R_DEPTH = 4;

  item_ctl_t      f_ctl;
  logic [W-1:0]   f_num;
  logic [W-1:0]   f_den;

  logic [Q_W-1:0] q_rdata;
  logic           q_empty;
  logic           q_pop;

  logic           c_ready;
  logic           c_valid;
  logic           c_inside;
  logic [AW-1:0]  c_angle;
  logic           r_full;
  logic [R_W-1:0] r_rdata;

  // Front: box registers and classification of the touch being pushed.
  tpa_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .touch_x   (touch_x),
    .touch_y   (touch_y),
    .ctl       (f_ctl),
    .num       (f_num),
    .den       (f_den)
  );

  // Queue of classified touches between front and CORDIC.
  tpa_fifo #(
    .WIDTH (Q_W),
    .DEPTH (Q_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .wdata ({f_ctl, f_num, f_den}),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  // Pop into the pipe whenever it advances.
  assign q_pop = c_ready && !q_empty;

  tpa_cordic #(
    .COORD_BITS      (COORD_BITS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .CORDIC_STAGES   (CORDIC_STAGES)
  ) u_cordic (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (!q_empty),
    .in_ready   (c_ready),
    .in_ctl     (item_ctl_t'(q_rdata[Q_W-1 -: CTL_W])),
    .in_num     (q_rdata[2*W-1 -: W]),
    .in_den     (q_rdata[W-1:0]),
    .out_valid  (c_valid),
    .out_ready  (!r_full),
    .out_inside (c_inside),
    .out_angle  (c_angle)
  );

  // Result queue decouples the pipe from the receiver.
  tpa_fifo #(
    .WIDTH (R_W),
    .DEPTH (R_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (c_valid),
    .full  (r_full),
    .wdata ({c_inside, c_angle}),
    .pop   (pop),
    .empty (empty),
    .rdata (r_rdata)
  );

  assign inside_box = r_rdata[R_W-1];
  assign angle_deg  = r_rdata[AW-1:0];

endmodule

FILE: tb/touch_point_to_angle_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_point_to_angle_unit_tb: self-checking bench for the joystick angle unit
// Streams touch points through the unit under several box settings and
// compares every result against a bit-exact CORDIC angle predictor.
// ----------------------------------------------------------------------------
module touch_point_to_angle_unit_tb;
  import tpa_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int FRAC_BITS     = 6;
  localparam int STAGES        = 16;
  // Pad after a drain; leave ample room before touching registers.
  localparam int DRAIN_PAD     = 40;
  // Receiver hold-off long enough to back the whole pipe up into full.
  localparam int LONG_HOLDOFF  = 400;
  localparam int MAX_REPORTED  = 10;
  localparam int RIGHT_ANGLE   = 90 << FRAC_BITS;
  localparam int FULL_TURN     = 360 << FRAC_BITS;

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
  } touch_pt_t;

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    logic        in_box;
    logic [14:0] angle;
  } touch_angle_t;

  // Receiver pop patterns.
  typedef enum logic [1:0] {
    RX_STREAM  = 2'd0,
    RX_RANDOM  = 2'd1,
    RX_STUTTER = 2'd2,
    RX_TRICKLE = 2'd3
  } rx_mode_t;

  // DUT connections, all inputs known from time zero.
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = REG_BOX_LEFT;
  logic [11:0] cfg_data  = '0;
  logic        push      = 1'b0;
  logic        full;
  logic [11:0] touch_x   = '0;
  logic [11:0] touch_y   = '0;
  logic        empty;
  logic        pop       = 1'b0;
  logic        inside_box;
  logic [14:0] angle_deg;

  // Bench copy of the box registers.
  logic [11:0] box_left_q = 12'(BOX_LEFT_RST);
  logic [11:0] box_top_q  = 12'(BOX_TOP_RST);
  logic [11:0] box_size_q = 12'(BOX_SIZE_RST);

  // atan(2^-i) in degrees with 16 fraction bits.
  longint atan_step_deg [16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  touch_pt_t    pending_touches [$];
  touch_angle_t expected_angles [$];
  touch_angle_t head_angle;

  int n_sent      = 0;
  int n_checked   = 0;
  int n_inside    = 0;
  int n_settings  = 1;
  int full_cycles = 0;
  int err_cnt     = 0;

  int burst_left  = 1;
  int gap_left    = 0;
  int holdoff_req = 0;
  int holdoff_ack = 0;
  int holdoff_left = 0;
  int rx_cycle    = 0;
  rx_mode_t rx_mode = RX_STREAM;
  logic rx_want;

  touch_point_to_angle_unit #(
    .COORD_BITS      (12),
    .ANGLE_FRAC_BITS (FRAC_BITS),
    .CORDIC_STAGES   (STAGES)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .touch_x    (touch_x),
    .touch_y    (touch_y),
    .empty      (empty),
    .pop        (pop),
    .inside_box (inside_box),
    .angle_deg  (angle_deg)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Angle predictor: box test, quadrant fold, vectoring CORDIC on the folded
  // ratio, round half up to FRAC_BITS, clamp to a right angle, add the base.
  // --------------------------------------------------------------------------
  function automatic touch_angle_t predict_angle(logic [11:0] tx, logic [11:0] ty);
    touch_angle_t r;
    longint px, py, lft, tp, sz, dx, dy, ax, ay, num, den;
    longint vx, vy, xs, ys, z, zr, total;
    quad_t quad;
    int i;
    r.x = tx;
    r.y = ty;
    r.in_box = 1'b0;
    r.angle = '0;
    px = tx;
    py = ty;
    lft = box_left_q;
    tp = box_top_q;
    sz = box_size_q;
    // Edges compare at full width, so a box hanging off screen never wraps.
    if (px < lft || px > lft + sz || py < tp || py > tp + sz)
      return r;
    r.in_box = 1'b1;
    dx = px - (lft + sz / 2);
    dy = py - (tp + sz / 2);
    // Exact center: no direction, angle stays zero.
    if (dx == 0 && dy == 0)
      return r;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (dx <= 0 && dy < 0) begin
      quad = QUAD_UP;    num = ax; den = ay;
    end else if (dx < 0 && dy >= 0) begin
      quad = QUAD_LEFT;  num = ay; den = ax;
    end else if (dx >= 0 && dy > 0) begin
      quad = QUAD_DOWN;  num = ax; den = ay;
    end else begin
      quad = QUAD_RIGHT; num = ay; den = ax;
    end
    vx = den <<< STAGES;
    vy = num <<< STAGES;
    z = 0;
    for (i = 0; i < STAGES; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy > 0) begin
        vx = vx + ys;
        vy = vy - xs;
        z = z + atan_step_deg[i];
      end else begin
        vx = vx - ys;
        vy = vy + xs;
        z = z - atan_step_deg[i];
      end
    end
    zr = (z + (longint'(1) <<< (ZFRAC - FRAC_BITS - 1))) >>> (ZFRAC - FRAC_BITS);
    if (zr < 0)
      zr = 0;
    if (zr > RIGHT_ANGLE)
      zr = RIGHT_ANGLE;
    // Base angle is the quadrant code times ninety degrees.
    total = longint'(quad) * RIGHT_ANGLE + zr;
    if (total >= FULL_TURN)
      total = total - FULL_TURN;
    r.angle = total[14:0];
    return r;
  endfunction

  function automatic logic [11:0] clip_coord(int v);
    if (v < 0)
      return '0;
    if (v > 4095)
      return 12'hFFF;
    return v[11:0];
  endfunction

  task automatic queue_touch(input int x, input int y);
    touch_pt_t t;
    t.x = clip_coord(x);
    t.y = clip_coord(y);
    pending_touches.push_back(t);
  endtask

  // Mostly points in and around the current box, with axis hits, points next
  // to the center, edge straddlers and fully random noise mixed in.
  task automatic queue_random_touches(input int n);
    int j, kind, lft, tp, sz, mx, my, rx, ry;
    lft = box_left_q;
    tp = box_top_q;
    sz = box_size_q;
    mx = lft + sz / 2;
    my = tp + sz / 2;
    for (j = 0; j < n; j++) begin
      kind = $urandom_range(0, 9);
      rx = $urandom_range(0, sz);
      ry = $urandom_range(0, sz);
      if (kind < 6) begin
        queue_touch(lft + rx, tp + ry);
      end else if (kind == 6) begin
        if ($urandom_range(0, 1) == 1)
          queue_touch(mx, tp + ry);
        else
          queue_touch(lft + rx, my);
      end else if (kind == 7) begin
        rx = $urandom_range(0, 6);
        ry = $urandom_range(0, 6);
        queue_touch(mx + rx - 3, my + ry - 3);
      end else if (kind == 8) begin
        rx = $urandom_range(0, 2);
        if ($urandom_range(0, 1) == 1)
          queue_touch(lft - 1 + rx, tp + ry);
        else
          queue_touch(lft + ry, tp + sz - 1 + rx);
      end else begin
        rx = $urandom_range(0, 4095);
        ry = $urandom_range(0, 4095);
        queue_touch(rx, ry);
      end
    end
  endtask

  // Write all three box registers back to back; only called while idle.
  task automatic set_box(input logic [11:0] lft, input logic [11:0] tp,
                         input logic [11:0] sz);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BOX_LEFT;
    cfg_data  <= lft;
    @(posedge clk);
    cfg_index <= REG_BOX_TOP;
    cfg_data  <= tp;
    @(posedge clk);
    cfg_index <= REG_BOX_SIZE;
    cfg_data  <= sz;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    box_left_q = lft;
    box_top_q  = tp;
    box_size_q = sz;
    n_settings++;
  endtask

  // Block until every queued touch has transferred and every result is back,
  // then let the pipe settle.
  task automatic wait_drain;
    @(posedge clk);
    while (pending_touches.size() != 0 || push || expected_angles.size() != 0)
      @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer touches in bursts of random length separated by random
  // gaps. A touch transfers on an edge with push high and full low; record its
  // predicted result at that edge, then load the next one or drop push.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        expected_angles.push_back(predict_angle(touch_x, touch_y));
        n_sent++;
      end
      // Hold the current touch while it is stalled by full.
      if (!push || !full) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          push     <= 1'b0;
        end else if (pending_touches.size() != 0) begin
          push    <= 1'b1;
          touch_x <= pending_touches[0].x;
          touch_y <= pending_touches[0].y;
          void'(pending_touches.pop_front());
          if (burst_left <= 1) begin
            // Some bursts run long with no gap at all after them.
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off: one request stalls pop until holdoff_left runs down
  // from LONG_HOLDOFF while the driver keeps pushing, so the unit must raise full.
  always @(posedge clk) begin
    if (holdoff_req != holdoff_ack) begin
      holdoff_ack  <= holdoff_req;
      holdoff_left <= LONG_HOLDOFF;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: a result transfers on an edge with pop high and empty low. Check
  // it against the oldest prediction, then pick pop for the next cycle from
  // the current receiver pattern.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (full)
        full_cycles++;
      if (pop && !empty) begin
        if (expected_angles.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTED)
            $display("%t: unexpected result inside_box=%0b angle_deg=%0d", $realtime,
                     inside_box, angle_deg);
        end else begin
          head_angle = expected_angles.pop_front();
          n_checked++;
          if (head_angle.in_box)
            n_inside++;
          if (inside_box !== head_angle.in_box || angle_deg !== head_angle.angle) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTED)
              $display("%t: touch (%0d,%0d) inside_box exp %0b got %0b, angle_deg exp %0d got %0d",
                       $realtime, head_angle.x, head_angle.y, head_angle.in_box,
                       inside_box, head_angle.angle, angle_deg);
          end
        end
      end
      // Switch pattern at each multiple of 64 in rx_cycle so stalls land on every pipe phase.
      rx_cycle++;
      if (rx_cycle % 64 == 0)
        rx_mode = rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_STREAM:  rx_want = 1'b1;
        RX_RANDOM:  rx_want = ($urandom_range(0, 1) == 1);
        RX_STUTTER: rx_want = (rx_cycle % 5 != 0);
        default:    rx_want = (rx_cycle % 8 < 2);
      endcase
      pop <= rx_want && (holdoff_left == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    int k, lft, tp, sz;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset box: left 150, top 0, size 200, center (250,100).
    queue_touch(250, 100);                       // center
    queue_touch(150, 0);    queue_touch(350, 200);  // corners
    queue_touch(150, 200);  queue_touch(350, 0);
    queue_touch(149, 100);  queue_touch(351, 100);  // just outside
    queue_touch(250, 201);
    queue_touch(0, 0);      queue_touch(4095, 4095);
    queue_touch(250, 50);   queue_touch(200, 100);  // axis points
    queue_touch(250, 150);  queue_touch(300, 100);
    queue_touch(200, 50);   queue_touch(200, 150);  // diagonals
    queue_touch(300, 150);  queue_touch(300, 50);
    queue_touch(349, 99);   queue_touch(251, 0);    // near an axis
    wait_drain();

    // Screen-sized box, then a box hanging off the far corner.
    set_box(12'd0, 12'd0, 12'd4095);
    queue_touch(0, 0);  queue_touch(2047, 2047);
    queue_touch(4095, 4095);  queue_touch(4095, 0);
    wait_drain();
    set_box(12'd4095, 12'd4095, 12'd4095);
    queue_touch(4095, 4095);  queue_touch(4094, 4095);
    wait_drain();

    // Zero-size box: a single point that is its own center.
    set_box(12'd7, 12'd9, 12'd0);
    queue_touch(7, 9);  queue_touch(8, 9);
    wait_drain();

    // Random part, back at the reset box, with the long hold-off.
    set_box(12'(BOX_LEFT_RST), 12'(BOX_TOP_RST), 12'(BOX_SIZE_RST));
    holdoff_req <= holdoff_req + 1;
    queue_random_touches(250);
    wait_drain();

    set_box(12'd0, 12'd0, 12'd4095);
    queue_random_touches(150);
    wait_drain();

    set_box(12'd4095, 12'd4095, 12'd4095);
    queue_random_touches(40);
    wait_drain();

    set_box(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), 12'd0);
    queue_random_touches(30);
    wait_drain();

    set_box(12'($urandom_range(0, 4094)), 12'($urandom_range(0, 4094)), 12'd1);
    queue_random_touches(30);
    wait_drain();

    // Random boxes kept on screen: tiny, mid-sized and large in turn.
    for (k = 0; k < 6; k++) begin
      case (k % 3)
        0:       sz = (k == 0) ? 2 : $urandom_range(2, 12);
        1:       sz = $urandom_range(13, 600);
        default: sz = $urandom_range(601, 3000);
      endcase
      lft = $urandom_range(0, 4095 - sz);
      tp  = $urandom_range(0, 4095 - sz);
      set_box(12'(lft), 12'(tp), 12'(sz));
      if (k == 4)
        holdoff_req <= holdoff_req + 1;
      queue_random_touches(110);
      wait_drain();
    end

    $display("Checked %0d of %0d touches (%0d inside the box) over %0d box settings.",
             n_checked, n_sent, n_inside, n_settings);
    $display("Input was held off by full for %0d cycles.", full_cycles);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatching results.", err_cnt);
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #3_200_000;
    $display("Timeout with %0d results outstanding.", expected_angles.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
src/tpa_pkg.sv
src/tpa_fifo.sv
src/tpa_front.sv
src/tpa_cordic.sv
src/touch_point_to_angle_unit.sv
tb/touch_point_to_angle_unit_tb.sv
